@@ sv/telemetry_frame_serializer_macros.svh @@
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst is high.
`ifndef TELEMETRY_FRAME_SERIALIZER_MACROS_SVH
`define TELEMETRY_FRAME_SERIALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tfs_pkg.sv @@
package tfs_pkg;

  localparam int ByteW        = 8;
  localparam int NumCells     = 16;
  localparam int CmdBodyBytes = 5;
  localparam int CfgIdxW      = 3;

  localparam logic [ByteW-1:0] HeadReset   = 8'hAA;
  localparam logic [ByteW-1:0] AddrReset   = 8'h62;
  localparam logic [ByteW-1:0] PoseIdReset = 8'h91;
  localparam logic [ByteW-1:0] CmdIdReset  = 8'h92;
  localparam logic [ByteW-1:0] PoseLenByte = 8'h0C;
  localparam logic [ByteW-1:0] CmdLenByte  = 8'h01;

  localparam logic ModePose = 1'b0;
  localparam logic ModeCmd  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD    = 3'd0,
    REG_ADDR    = 3'd1,
    REG_POSE_ID = 3'd2,
    REG_CMD_ID  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [7:0]  command_code;
  } tfs_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } tfs_byte_t;

  typedef struct packed {
    logic             valid;
    logic             end_flag;
    logic [ByteW-1:0] data;
  } tfs_cell_t;

endpackage

@@ sv/tfs_cell.sv @@
module tfs_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               shift,
  input  tfs_pkg::tfs_cell_t load_val,
  input  tfs_pkg::tfs_cell_t nbr,
  output tfs_pkg::tfs_cell_t slot
);
  import tfs_pkg::*;

  // A load wins over a shift: it only coincides with popping the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot <= load_val;
    end else if (shift) begin
      slot <= nbr;
    end
  end

endmodule

@@ sv/tfs_emit.sv @@
module tfs_emit (
  input  logic               clk,
  input  logic               rst,
  input  tfs_pkg::tfs_cell_t head,
  output logic               pop,
  output logic               frm_valid,
  input  logic               frm_stall,
  output tfs_pkg::tfs_byte_t frm
);
  import tfs_pkg::*;

  typedef enum logic [1:0] {
    PH_BODY,
    PH_SUM,
    PH_ADDON
  } phase_t;

  phase_t           phase;
  logic [ByteW-1:0] sum;
  logic [ByteW-1:0] addon;
  logic [ByteW-1:0] sum_next;
  logic [ByteW-1:0] addon_next;
  logic             out_free;

  assign out_free   = !frm_valid || !frm_stall;
  assign pop        = out_free && (phase == PH_BODY) && head.valid;
  assign sum_next   = sum + head.data;
  assign addon_next = addon + sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BODY;
      sum       <= '0;
      addon     <= '0;
      frm_valid <= 1'b0;
    end else if (out_free) begin
      unique case (phase)
        PH_BODY: begin
          frm_valid <= head.valid;
          if (head.valid) begin
            frm.data_byte <= head.data;
            frm.last_byte <= 1'b0;
            sum           <= sum_next;
            addon         <= addon_next;
            if (head.end_flag) begin
              phase <= PH_SUM;
            end
          end
        end
        PH_SUM: begin
          frm_valid     <= 1'b1;
          frm.data_byte <= sum;
          frm.last_byte <= 1'b0;
          phase         <= PH_ADDON;
        end
        PH_ADDON: begin
          frm_valid     <= 1'b1;
          frm.data_byte <= addon;
          frm.last_byte <= 1'b1;
          sum           <= '0;
          addon         <= '0;
          phase         <= PH_BODY;
        end
        default: begin
          phase <= PH_BODY;
        end
      endcase
    end
  end

endmodule

@@ sv/telemetry_frame_serializer.sv @@
// Telemetry frame serializer.
// An item request (item_valid/item_stall) carries a frame type and its fields.
// The block sends the frame one byte at a time on the frm channel
// (frm_valid/frm_stall) and sets last_byte on the closing add-on check byte.
// A pose frame is 18 bytes, a command frame 7 bytes.
// The frame body is loaded in parallel into a row of 16 byte cells that shift
// toward the output; the output stage accumulates both check bytes as body
// bytes pass and appends them.
// An accepted body is registered in the cells and then in the output stage.
// An item taken as the previous frame ends follows that frame's two check bytes.
// Throughput: one byte per cycle while frm_stall does not hold the output; the
// next item is taken in the cycle the last body byte leaves the row, before
// the previous frame's check bytes are sent.
// When a valid byte meets frm_stall, it holds and the row stops shifting;
// item_stall rises as soon as the row cannot take a new frame.
// The cfg channel (cfg_valid/cfg_ready) writes the four header registers and
// is always ready; indexes beyond the last register are ignored.
// Reset (rst, synchronous) empties the row and the output stage and restores
// the register defaults.
module telemetry_frame_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  tfs_pkg::tfs_item_t            item,
  output logic                          frm_valid,
  input  logic                          frm_stall,
  output tfs_pkg::tfs_byte_t            frm,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tfs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tfs_pkg::ByteW-1:0]     cfg_data
);
  import tfs_pkg::*;

  logic [ByteW-1:0] head_byte;
  logic [ByteW-1:0] target_address;
  logic [ByteW-1:0] pose_frame_id;
  logic [ByteW-1:0] command_frame_id;

  tfs_cell_t        cells    [NumCells];
  tfs_cell_t        load_val [NumCells];
  logic [ByteW-1:0] body     [NumCells];
  logic             load;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte        <= HeadReset;
      target_address   <= AddrReset;
      pose_frame_id    <= PoseIdReset;
      command_frame_id <= CmdIdReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD:    head_byte        <= cfg_data;
        REG_ADDR:    target_address   <= cfg_data;
        REG_POSE_ID: pose_frame_id    <= cfg_data;
        REG_CMD_ID:  command_frame_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumCells; i++) begin
      body[i] = '0;
    end
    body[0] = head_byte;
    body[1] = target_address;
    if (item.mode == ModePose) begin
      body[2]  = pose_frame_id;
      body[3]  = PoseLenByte;
      body[4]  = item.pos_x[7:0];
      body[5]  = item.pos_x[15:8];
      body[6]  = item.pos_y[7:0];
      body[7]  = item.pos_y[15:8];
      body[8]  = item.pos_z[7:0];
      body[9]  = item.pos_z[15:8];
      body[10] = item.vel_x[7:0];
      body[11] = item.vel_x[15:8];
      body[12] = item.vel_y[7:0];
      body[13] = item.vel_y[15:8];
      body[14] = item.vel_z[7:0];
      body[15] = item.vel_z[15:8];
    end else begin
      body[2] = command_frame_id;
      body[3] = CmdLenByte;
      body[4] = item.command_code;
    end
    for (int i = 0; i < NumCells; i++) begin
      load_val[i].data     = body[i];
      load_val[i].valid    = (item.mode == ModePose) || (i < CmdBodyBytes);
      load_val[i].end_flag = (item.mode == ModePose) ? (i == NumCells - 1)
                                                     : (i == CmdBodyBytes - 1);
    end
  end

  // The row can take a frame when empty, or when its last byte leaves now.
  assign item_stall = !(!cells[0].valid || (cells[0].valid && !cells[1].valid && pop));
  assign load       = item_valid && !item_stall;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    tfs_cell_t nbr;
    if (g == NumCells - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[g+1];
    end
    tfs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (load),
      .shift    (pop),
      .load_val (load_val[g]),
      .nbr      (nbr),
      .slot     (cells[g])
    );
  end

  tfs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (cells[0]),
    .pop       (pop),
    .frm_valid (frm_valid),
    .frm_stall (frm_stall),
    .frm       (frm)
  );

endmodule

@@ sv/tfs_checker.sv @@
`include "telemetry_frame_serializer_macros.svh"

module tfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic                          frm_valid,
  input logic                          frm_stall,
  input tfs_pkg::tfs_byte_t            frm
);
  import tfs_pkg::*;

  logic frm_wait;
  logic item_take;
  logic last_out;

  assign frm_wait  = frm_valid && frm_stall;
  assign item_take = item_valid && !item_stall;
  assign last_out  = frm_valid && frm.last_byte;

  // A stalled output byte stays put.
  `TFS_ASSERT_NEXT(a_frm_hold, frm_wait, frm_valid && $stable(frm), "frm changed under stall")

  // After an item is taken, item_stall is high: the freshly loaded frame occupies the row.
  `TFS_ASSERT_NEXT(a_item_busy, item_take, item_stall, "item taken twice in a row")

  // Two closing check bytes never follow each other.
  `TFS_ASSERT_NEXT(a_last_gap, last_out && !frm_stall, !last_out, "back-to-back last bytes")

  // Reset leaves nothing on the output.
  `TFS_ASSERT_NOW(a_rst_empty, $past(rst), !frm_valid, "output valid right after reset")

endmodule

bind telemetry_frame_serializer tfs_checker u_tfs_checker (.*);
